// ----- hw/rtl/fraction_add_reduce_assert.svh -----
// Assertion macros shared by the fraction adder RTL.
`ifndef FRACTION_ADD_REDUCE_ASSERT_SVH
`define FRACTION_ADD_REDUCE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FAR_ASSERT_NOW(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FAR_ASSERT_NEXT(name, clock, reset, ante, cons, msg) \
  name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/far_pkg.sv -----
// Types, widths and datapath operation codes for the fraction adder.
`default_nettype none

package far_pkg;

  localparam int OPERAND_BITS = 16;
  localparam int SUM_BITS     = 2 * OPERAND_BITS + 1;
  localparam int DEN_BITS     = 2 * OPERAND_BITS;
  localparam int DIV_STEPS    = SUM_BITS;
  localparam int CNT_BITS     = $clog2(DIV_STEPS);
  localparam int SHIFT_BITS   = $clog2(DEN_BITS + 1);

  typedef struct packed {
    logic [OPERAND_BITS-1:0] num_a;
    logic [OPERAND_BITS-1:0] den_a;
    logic [OPERAND_BITS-1:0] num_b;
    logic [OPERAND_BITS-1:0] den_b;
  } operands_t;

  typedef struct packed {
    logic [SUM_BITS-1:0] sum_num;
    logic [DEN_BITS-1:0] sum_den;
    logic [SUM_BITS-1:0] whole_part;
    logic [DEN_BITS-1:0] rem_num;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_ADD,
    OP_MAC_A,
    OP_MAC_B,
    OP_MUL_D,
    OP_GCD_INIT,
    OP_TWOS,
    OP_GCD_STEP,
    OP_DIV_NUM,
    OP_DIV_DEN,
    OP_DIV_MIX,
    OP_DIV_STEP,
    OP_FINISH,
    OP_FINISH_ZERO
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic eq_den;
    logic sum_zero;
    logic both_even;
    logic gcd_done;
    logic div_last;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fraction_add_reduce.sv -----
// Top level of the fraction adder with reduction to lowest terms.
//
// Usage: drive operands and raise start; the transaction is taken at a clock
// edge where start is high and busy is low. busy stays high while the sum is
// formed, reduced and split into its mixed form. The result is held on result
// and done is high for exactly one cycle; the receiver must take it then.
// Equal denominators add the numerators directly; unequal ones go through the
// cross multiplies. A zero sum or denominator skips the reduction, which uses
// the binary GCD loop (one shift, or subtract and shift, per cycle) and three
// 33-step restoring divisions sharing one divider. One transaction is in
// flight at a time; a new one may be accepted in the cycle done is high.
// Reset (rst, synchronous) returns the controller to idle and clears done.
`default_nettype none

module fraction_add_reduce (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire far_pkg::operands_t  operands,
  output logic                     done,
  output far_pkg::result_t         result
);
  import far_pkg::*;
  `include "fraction_add_reduce_assert.svh"

  dp_cmd_t    cmd;
  dp_status_t status;

  far_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  far_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .operands (operands),
    .cmd      (cmd),
    .status   (status),
    .done     (done),
    .result   (result)
  );

  `FAR_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "busy not set after accept")
  `FAR_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held for more than one cycle")
  `FAR_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobed while still busy")

endmodule

`default_nettype wire

// ----- hw/rtl/far_dp.sv -----
// Datapath: operand registers, shared multiplier, binary GCD and restoring divider.
`default_nettype none

module far_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire far_pkg::operands_t   operands,
  input  wire far_pkg::dp_cmd_t     cmd,
  output far_pkg::dp_status_t       status,
  output logic                      done,
  output far_pkg::result_t          result
);
  import far_pkg::*;

  operands_t               opnd;
  logic [SUM_BITS-1:0]     num;
  logic [DEN_BITS-1:0]     den;
  logic [SUM_BITS-1:0]     ga;
  logic [SUM_BITS-1:0]     gb;
  logic [SHIFT_BITS-1:0]   k;
  logic [SUM_BITS-1:0]     quo;
  logic [DEN_BITS-1:0]     rem;
  logic [DEN_BITS-1:0]     dvs;
  logic [CNT_BITS-1:0]     cnt;
  result_t                 res;

  logic [OPERAND_BITS-1:0] mul_x;
  logic [OPERAND_BITS-1:0] mul_y;
  logic [DEN_BITS-1:0]     prod;
  logic [DEN_BITS-1:0]     g_val;
  logic [SUM_BITS-1:0]     sh;
  logic [SUM_BITS-1:0]     dv_ext;
  logic [SUM_BITS-1:0]     diff;
  logic                    ge;

  always_comb begin
    case (cmd.op)
      OP_MAC_A: begin
        mul_x = opnd.den_b;
        mul_y = opnd.num_a;
      end
      OP_MAC_B: begin
        mul_x = opnd.den_a;
        mul_y = opnd.num_b;
      end
      default: begin
        mul_x = opnd.den_a;
        mul_y = opnd.den_b;
      end
    endcase
  end

  assign prod   = DEN_BITS'(mul_x) * DEN_BITS'(mul_y);
  assign g_val  = ga[DEN_BITS-1:0] << k;
  assign sh     = {rem, quo[SUM_BITS-1]};
  assign dv_ext = {1'b0, dvs};
  assign ge     = sh >= dv_ext;
  assign diff   = sh - dv_ext;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        opnd <= operands;
      end
      OP_ADD: begin
        num <= SUM_BITS'(opnd.num_a) + SUM_BITS'(opnd.num_b);
        den <= DEN_BITS'(opnd.den_a);
      end
      OP_MAC_A: begin
        num <= SUM_BITS'(prod);
      end
      OP_MAC_B: begin
        num <= num + SUM_BITS'(prod);
      end
      OP_MUL_D: begin
        den <= prod;
      end
      OP_GCD_INIT: begin
        ga <= num;
        gb <= SUM_BITS'(den);
        k  <= '0;
      end
      OP_TWOS: begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + 1'b1;
      end
      OP_GCD_STEP: begin
        if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (ga > gb) begin
          ga <= (ga - gb) >> 1;
        end else begin
          gb <= (gb - ga) >> 1;
        end
      end
      OP_DIV_NUM: begin
        quo <= num;
        dvs <= g_val;
        rem <= '0;
        cnt <= '0;
      end
      OP_DIV_DEN: begin
        num <= quo;
        quo <= SUM_BITS'(den);
        dvs <= g_val;
        rem <= '0;
        cnt <= '0;
      end
      OP_DIV_MIX: begin
        den <= quo[DEN_BITS-1:0];
        quo <= num;
        dvs <= quo[DEN_BITS-1:0];
        rem <= '0;
        cnt <= '0;
      end
      OP_DIV_STEP: begin
        quo <= {quo[SUM_BITS-2:0], ge};
        rem <= ge ? diff[DEN_BITS-1:0] : sh[DEN_BITS-1:0];
        cnt <= cnt + 1'b1;
      end
      OP_FINISH: begin
        res.sum_num    <= num;
        res.sum_den    <= den;
        res.whole_part <= quo;
        res.rem_num    <= rem;
      end
      OP_FINISH_ZERO: begin
        res.sum_num    <= num;
        res.sum_den    <= den;
        res.whole_part <= '0;
        res.rem_num    <= '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_FINISH) || (cmd.op == OP_FINISH_ZERO);
    end
  end

  assign status.eq_den    = opnd.den_a == opnd.den_b;
  assign status.sum_zero  = (num == '0) || (den == '0);
  assign status.both_even = !ga[0] && !gb[0];
  assign status.gcd_done  = ga == gb;
  assign status.div_last  = cnt == CNT_BITS'(DIV_STEPS - 1);
  assign result           = res;

endmodule

`default_nettype wire

// ----- hw/rtl/far_ctrl.sv -----
// Controller: sequences load, multiply, GCD and the three divisions.
`default_nettype none

module far_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire far_pkg::dp_status_t status,
  output far_pkg::dp_cmd_t         cmd,
  output logic                     busy
);
  import far_pkg::*;

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_SUM      = 13'b0000000000010,
    ST_MAC_B    = 13'b0000000000100,
    ST_MUL_D    = 13'b0000000001000,
    ST_CHECK    = 13'b0000000010000,
    ST_TWOS     = 13'b0000000100000,
    ST_GCD      = 13'b0000001000000,
    ST_DIVN     = 13'b0000010000000,
    ST_DIVD_SET = 13'b0000100000000,
    ST_DIVD     = 13'b0001000000000,
    ST_DIVM_SET = 13'b0010000000000,
    ST_DIVM     = 13'b0100000000000,
    ST_FINISH   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (status.eq_den) begin
          cmd.op     = OP_ADD;
          state_next = ST_CHECK;
        end else begin
          cmd.op     = OP_MAC_A;
          state_next = ST_MAC_B;
        end
      end
      ST_MAC_B: begin
        cmd.op     = OP_MAC_B;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        cmd.op     = OP_MUL_D;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.sum_zero) begin
          cmd.op     = OP_FINISH_ZERO;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = OP_GCD_INIT;
          state_next = ST_TWOS;
        end
      end
      ST_TWOS: begin
        if (status.both_even) begin
          cmd.op = OP_TWOS;
        end else begin
          state_next = ST_GCD;
        end
      end
      ST_GCD: begin
        if (status.gcd_done) begin
          cmd.op     = OP_DIV_NUM;
          state_next = ST_DIVN;
        end else begin
          cmd.op = OP_GCD_STEP;
        end
      end
      ST_DIVN: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = ST_DIVD_SET;
        end
      end
      ST_DIVD_SET: begin
        cmd.op     = OP_DIV_DEN;
        state_next = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = ST_DIVM_SET;
        end
      end
      ST_DIVM_SET: begin
        cmd.op     = OP_DIV_MIX;
        state_next = ST_DIVM;
      end
      ST_DIVM: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.op     = OP_FINISH;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != ST_IDLE;

endmodule

`default_nettype wire
